/* src/dbtd_pkg.sv */
// dbtd_pkg: shared types and constants for the dual band biquad tone detector
// used by the channel interfaces, controller, datapath and top level
package dbtd_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int DATA_W     = 32;
  localparam int COEF_W     = 60;
  localparam int COEFF_REGS = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int A_W        = 13;
  localparam int G_W        = 4;

  localparam int WINDOW_LENGTH_DEF = 16;
  localparam int NUM_STAGES_DEF    = 4;
  localparam int FRAC_BITS_DEF     = 9;
  localparam int SAMPLE_BITS_DEF   = 12;

  localparam logic signed [DATA_W-1:0] LOW_THR_RST  = 32'sd500;
  localparam logic signed [DATA_W-1:0] HIGH_THR_RST = 32'sd150;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STAGE0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 3'd5;

  localparam logic BAND_LOW  = 1'b0;
  localparam logic BAND_HIGH = 1'b1;

  typedef enum logic [2:0] {
    TERM_X0,
    TERM_X1,
    TERM_X2,
    TERM_Y1,
    TERM_Y2,
    TERM_GAIN
  } term_t;

  typedef struct packed {
    logic  load;
    logic  issue;
    term_t term;
    logic  band;
    logic  last_stage;
    logic  hist_wr;
    logic  first;
    logic  emit;
  } dp_cmd_t;

endpackage

/* src/dbtd_in_if.sv */
// dbtd_in_if: sample input channel, valid/ready handshake
// depends on dbtd_pkg
interface dbtd_in_if;
  import dbtd_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

/* src/dbtd_out_if.sv */
// dbtd_out_if: window result channel, valid/ready handshake
// depends on dbtd_pkg
interface dbtd_out_if;
  import dbtd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     low_tone_detected;
  logic                     high_tone_detected;
  logic signed [DATA_W-1:0] low_band_peak;
  logic signed [DATA_W-1:0] high_band_peak;

  modport source (output valid, output low_tone_detected, output high_tone_detected,
                  output low_band_peak, output high_band_peak, input ready);
  modport sink (input valid, input low_tone_detected, input high_tone_detected,
                input low_band_peak, input high_band_peak, output ready);
endinterface

/* src/dbtd_cfg_if.sv */
// dbtd_cfg_if: configuration write channel, register index and write data
// depends on dbtd_pkg
interface dbtd_cfg_if;
  import dbtd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/dual_band_biquad_tone_detector.sv */
// dual_band_biquad_tone_detector: top level, configuration registers and wiring
// depends on dbtd_pkg, the dbtd channel interfaces, dbtd_ctrl and dbtd_dp
//
// Usage:
//   in_ch carries one 12-bit ADC sample per item. in_ch.ready is high only
//   while the block is idle; an accepted item runs through both four-stage
//   biquad cascades on one shared 32x32 multiplier, six products per stage
//   per band, so an item occupies the block from acceptance until in_ch.ready
//   returns, and no new item is taken before the last one is through.
//   out_ch gives one item per window of WINDOW_LENGTH samples: both band peaks
//   and both threshold bits, valid once the window's last sample finishes
//   and the output is free; the result waits in it, so the next samples are
//   taken while it waits; if the next window ends before it is taken, the
//   block holds in its final step with in_ch.ready low until out_ch.ready.
//   cfg_ch is always ready; registers 0..3 hold per-stage coefficients, 4 and
//   5 the low and high thresholds. Write it only while the block is idle.
//   Reset (rst_n low, synchronous) clears all filter history, the peaks and
//   the window position and restores the default thresholds; there is no
//   clearing pass, the block is ready the cycle after reset.
module dual_band_biquad_tone_detector #(
  parameter int WINDOW_LENGTH = dbtd_pkg::WINDOW_LENGTH_DEF,
  parameter int NUM_STAGES    = dbtd_pkg::NUM_STAGES_DEF,
  parameter int FRAC_BITS     = dbtd_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_BITS   = dbtd_pkg::SAMPLE_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  dbtd_in_if.sink     in_ch,
  dbtd_out_if.source  out_ch,
  dbtd_cfg_if.sink    cfg_ch
);
  import dbtd_pkg::*;

  localparam int STG_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

  logic [COEF_W-1:0]        coef_r [COEFF_REGS];
  logic signed [DATA_W-1:0] low_thr_r;
  logic signed [DATA_W-1:0] high_thr_r;
  dp_cmd_t                  cmd;
  logic [STG_W-1:0]         cmd_stage;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COEFF_REGS; i++) begin
        coef_r[i] <= '0;
      end
      low_thr_r  <= LOW_THR_RST;
      high_thr_r <= HIGH_THR_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_STAGE0:   coef_r[0]  <= cfg_ch.data;
        REG_STAGE1:   coef_r[1]  <= cfg_ch.data;
        REG_STAGE2:   coef_r[2]  <= cfg_ch.data;
        REG_STAGE3:   coef_r[3]  <= cfg_ch.data;
        REG_LOW_THR:  low_thr_r  <= cfg_ch.data[DATA_W-1:0];
        REG_HIGH_THR: high_thr_r <= cfg_ch.data[DATA_W-1:0];
        default:      low_thr_r  <= low_thr_r;
      endcase
    end
  end

  dbtd_ctrl #(
    .NUM_STAGES    (NUM_STAGES),
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .cmd_stage (cmd_stage)
  );

  dbtd_dp #(
    .NUM_STAGES  (NUM_STAGES),
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_stage (cmd_stage),
    .sample    (in_ch.sample),
    .coef      (coef_r),
    .low_thr   (low_thr_r),
    .high_thr  (high_thr_r),
    .low_det   (out_ch.low_tone_detected),
    .high_det  (out_ch.high_tone_detected),
    .low_peak  (out_ch.low_band_peak),
    .high_peak (out_ch.high_band_peak)
  );

  // an accepted item keeps the input closed while it is processed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after accepting an item");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("result emitted over a pending item");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_ch.valid)
    else $error("emitted result not presented");

  // sample load and multiplier issue never overlap
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && (cmd.issue || cmd.hist_wr)))
    else $error("sample loaded while the datapath is busy");
endmodule

/* src/dbtd_ctrl.sv */
// dbtd_ctrl: sequencer for the shared multiply-accumulate datapath
// walks band, stage and term for each item and tracks the window; uses dbtd_pkg
module dbtd_ctrl #(
  parameter int NUM_STAGES    = dbtd_pkg::NUM_STAGES_DEF,
  parameter int WINDOW_LENGTH = dbtd_pkg::WINDOW_LENGTH_DEF,
  localparam int STG_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output dbtd_pkg::dp_cmd_t cmd,
  output logic [STG_W-1:0]  cmd_stage
);
  import dbtd_pkg::*;

  localparam int WIN_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t           state_r;
  logic [2:0]       ph_r;
  logic             band_r;
  logic [STG_W-1:0] stage_r;
  logic [WIN_W-1:0] win_r;
  logic             out_valid_r;

  logic last_stage;
  logic win_end;
  logic out_free;

  assign last_stage = (stage_r == STG_W'(NUM_STAGES - 1));
  assign win_end    = (win_r == WIN_W'(WINDOW_LENGTH - 1));
  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd_stage  = stage_r;

  always_comb begin
    cmd            = '0;
    cmd.load       = (state_r == S_IDLE) && in_valid;
    cmd.issue      = (state_r == S_RUN) && ((ph_r < 3'd5) || (ph_r == 3'd6));
    cmd.band       = band_r;
    cmd.last_stage = last_stage;
    cmd.hist_wr    = (state_r == S_RUN) && (ph_r == 3'd6);
    cmd.first      = (win_r == '0);
    cmd.emit       = (state_r == S_DONE) && win_end && out_free;
    case (ph_r)
      3'd0:    cmd.term = TERM_X0;
      3'd1:    cmd.term = TERM_X1;
      3'd2:    cmd.term = TERM_X2;
      3'd3:    cmd.term = TERM_Y1;
      3'd4:    cmd.term = TERM_Y2;
      default: cmd.term = TERM_GAIN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= '0;
      band_r      <= BAND_LOW;
      stage_r     <= '0;
      win_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_RUN;
            ph_r    <= '0;
            band_r  <= BAND_LOW;
            stage_r <= '0;
          end
        end
        S_RUN: begin
          ph_r <= ph_r + 3'd1;
          if (ph_r == 3'd7) begin
            if (last_stage) begin
              stage_r <= '0;
              if (band_r == BAND_HIGH) begin
                band_r  <= BAND_LOW;
                state_r <= S_DONE;
              end else begin
                band_r <= BAND_HIGH;
              end
            end else begin
              stage_r <= stage_r + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (!win_end) begin
            win_r   <= win_r + 1'b1;
            state_r <= S_IDLE;
          end else if (out_free) begin
            win_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule

/* src/dbtd_dp.sv */
// dbtd_dp: shared multiplier, accumulator, biquad history and window peaks
// driven by dbtd_ctrl commands; uses dbtd_pkg
module dbtd_dp #(
  parameter int NUM_STAGES  = dbtd_pkg::NUM_STAGES_DEF,
  parameter int FRAC_BITS   = dbtd_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = dbtd_pkg::SAMPLE_BITS_DEF,
  localparam int STG_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dbtd_pkg::dp_cmd_t                  cmd,
  input  logic [STG_W-1:0]                   cmd_stage,
  input  logic [dbtd_pkg::SAMPLE_W-1:0]      sample,
  input  logic [dbtd_pkg::COEF_W-1:0]        coef [dbtd_pkg::COEFF_REGS],
  input  logic signed [dbtd_pkg::DATA_W-1:0] low_thr,
  input  logic signed [dbtd_pkg::DATA_W-1:0] high_thr,
  output logic                               low_det,
  output logic                               high_det,
  output logic signed [dbtd_pkg::DATA_W-1:0] low_peak,
  output logic signed [dbtd_pkg::DATA_W-1:0] high_peak
);
  import dbtd_pkg::*;

  localparam logic signed [DATA_W-1:0] ONE     = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [DATA_W-1:0] TWO     = ONE <<< 1;
  localparam logic signed [DATA_W-1:0] NEG_TWO = -TWO;
  localparam logic signed [DATA_W-1:0] RND     = ONE - 32'sd1;
  localparam logic [SAMPLE_W-1:0] SMP_MASK = SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);

  logic signed [DATA_W-1:0] smp_r;
  logic signed [DATA_W-1:0] x_r;
  logic signed [DATA_W-1:0] prod_r;
  logic signed [DATA_W-1:0] acc_r;
  logic signed [DATA_W-1:0] lo_out_r;
  logic signed [DATA_W-1:0] lo_peak_r;
  logic signed [DATA_W-1:0] hi_peak_r;
  logic signed [DATA_W-1:0] x1_r [2][NUM_STAGES];
  logic signed [DATA_W-1:0] x2_r [2][NUM_STAGES];
  logic signed [DATA_W-1:0] y1_r [2][NUM_STAGES];
  logic signed [DATA_W-1:0] y2_r [2][NUM_STAGES];
  dp_cmd_t                  cmd_d_r;
  logic                     low_det_r;
  logic                     high_det_r;
  logic signed [DATA_W-1:0] low_peak_r;
  logic signed [DATA_W-1:0] high_peak_r;

  logic [COEF_W-1:0]        cur_coef;
  logic [A_W-1:0]           a1;
  logic [A_W-1:0]           a2;
  logic [G_W-1:0]           gain;
  logic signed [DATA_W-1:0] op_a;
  logic signed [DATA_W-1:0] op_b;
  logic signed [DATA_W-1:0] mul;
  logic signed [DATA_W-1:0] q_adj;
  logic signed [DATA_W-1:0] q;
  logic [DATA_W-1:0]        smp_in;

  // stages without a coefficient register read as all zero
  always_comb begin
    cur_coef = '0;
    for (int i = 0; i < COEFF_REGS; i++) begin
      if ((i < NUM_STAGES) && (int'(cmd_stage) == i)) begin
        cur_coef = coef[i];
      end
    end
  end

  assign a1   = cmd.band ? cur_coef[38:26] : cur_coef[12:0];
  assign a2   = cmd.band ? cur_coef[51:39] : cur_coef[25:13];
  assign gain = cmd.band ? cur_coef[59:56] : cur_coef[55:52];

  always_comb begin
    case (cmd.term)
      TERM_X0: begin
        op_a = ONE;
        op_b = x_r;
      end
      TERM_X1: begin
        op_a = (int'(cmd_stage) < NUM_STAGES / 2) ? TWO : NEG_TWO;
        op_b = x1_r[cmd.band][cmd_stage];
      end
      TERM_X2: begin
        op_a = ONE;
        op_b = x2_r[cmd.band][cmd_stage];
      end
      TERM_Y1: begin
        op_a = {{(DATA_W - A_W){a1[A_W-1]}}, a1};
        op_b = y1_r[cmd.band][cmd_stage];
      end
      TERM_Y2: begin
        op_a = {{(DATA_W - A_W){a2[A_W-1]}}, a2};
        op_b = y2_r[cmd.band][cmd_stage];
      end
      TERM_GAIN: begin
        op_a = acc_r;
        op_b = {{(DATA_W - G_W){1'b0}}, gain};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul    = op_a * op_b;
  // truncate toward zero on the scale-down
  assign q_adj  = prod_r + (prod_r[DATA_W-1] ? RND : 32'sd0);
  assign q      = q_adj >>> FRAC_BITS;
  assign smp_in = {{(DATA_W - SAMPLE_W){1'b0}}, sample & SMP_MASK};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_d_r   <= '0;
      lo_peak_r <= '0;
      hi_peak_r <= '0;
      for (int b = 0; b < 2; b++) begin
        for (int s = 0; s < NUM_STAGES; s++) begin
          x1_r[b][s] <= '0;
          x2_r[b][s] <= '0;
          y1_r[b][s] <= '0;
          y2_r[b][s] <= '0;
        end
      end
    end else begin
      cmd_d_r <= cmd;
      if (cmd.hist_wr) begin
        x2_r[cmd.band][cmd_stage] <= x1_r[cmd.band][cmd_stage];
        x1_r[cmd.band][cmd_stage] <= x_r;
        y2_r[cmd.band][cmd_stage] <= y1_r[cmd.band][cmd_stage];
        y1_r[cmd.band][cmd_stage] <= acc_r;
      end
      if (cmd_d_r.issue && (cmd_d_r.term == TERM_GAIN) && cmd_d_r.last_stage &&
          (cmd_d_r.band == BAND_HIGH)) begin
        if (cmd_d_r.first) begin
          lo_peak_r <= lo_out_r;
          hi_peak_r <= q;
        end else begin
          if (lo_out_r > lo_peak_r) begin
            lo_peak_r <= lo_out_r;
          end
          if (q > hi_peak_r) begin
            hi_peak_r <= q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r <= smp_in;
      x_r   <= smp_in;
    end
    if (cmd.issue) begin
      prod_r <= mul;
    end
    if (cmd_d_r.issue) begin
      case (cmd_d_r.term)
        TERM_X0:          acc_r <= q;
        TERM_X1, TERM_X2: acc_r <= acc_r + q;
        TERM_Y1, TERM_Y2: acc_r <= acc_r - q;
        TERM_GAIN: begin
          if (!cmd_d_r.last_stage) begin
            x_r <= q;
          end else begin
            x_r <= smp_r;
            if (cmd_d_r.band == BAND_LOW) begin
              lo_out_r <= q;
            end
          end
        end
        default: acc_r <= acc_r;
      endcase
    end
    if (cmd.emit) begin
      low_det_r   <= (lo_peak_r > low_thr);
      high_det_r  <= (hi_peak_r > high_thr);
      low_peak_r  <= lo_peak_r;
      high_peak_r <= hi_peak_r;
    end
  end

  assign low_det   = low_det_r;
  assign high_det  = high_det_r;
  assign low_peak  = low_peak_r;
  assign high_peak = high_peak_r;
endmodule
